### design/sai_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_pkg
// Shared types and constants of the sorted array insert unit.
// ----------------------------------------------------------------------------
package sai_pkg;

    localparam int CAPACITY    = 32;
    localparam int STORE_DEPTH = 32;
    localparam int USABLE_CAP  = (CAPACITY < STORE_DEPTH) ? CAPACITY : STORE_DEPTH;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CW          = AW + 1;
    localparam int DW          = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QW          = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOT_ASC = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_NOT_ASC = 2'd1,
        OP_FULL    = 2'd2,
        OP_INSERT  = 2'd3
    } op_t;

    typedef struct packed {
        op_t           op;
        logic [DW-1:0] value;
        logic [CW-1:0] cnt;
    } job_t;

endpackage

### design/sai_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_front
// Accepts input beats and classifies them against a shadow count and maximum.
// ----------------------------------------------------------------------------
module sai_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic signed [sai_pkg::DW-1:0] s_value,
    output logic                          push,
    output sai_pkg::job_t                 push_job,
    input  logic                          q_full
);

    logic [sai_pkg::CW-1:0] cnt_reg, cnt_next;
    logic [sai_pkg::DW-1:0] max_reg, max_next;
    logic                   full;
    logic                   below;

    assign s_ready = !q_full;
    assign push    = s_valid && s_ready;
    assign full    = (cnt_reg >= sai_pkg::CW'(sai_pkg::USABLE_CAP));
    assign below   = (cnt_reg != '0) && (s_value < $signed(max_reg));

    always_comb begin
        cnt_next       = cnt_reg;
        max_next       = max_reg;
        push_job.value = s_value;
        push_job.cnt   = cnt_reg;
        push_job.op    = sai_pkg::OP_FULL;
        if (full) begin
            push_job.op = sai_pkg::OP_FULL;
        end else if (s_kind == sai_pkg::KIND_LOAD) begin
            if (below) begin
                push_job.op = sai_pkg::OP_NOT_ASC;
            end else begin
                push_job.op = sai_pkg::OP_LOAD;
                cnt_next    = cnt_reg + 1'b1;
                max_next    = s_value;
            end
        end else begin
            push_job.op = sai_pkg::OP_INSERT;
            cnt_next    = cnt_reg + 1'b1;
            if (!below) begin
                max_next = s_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (push) begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            max_reg <= max_next;
        end
    end

endmodule

### design/sai_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_queue
// Short job queue between the classifying front and the memory back end.
// ----------------------------------------------------------------------------
module sai_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sai_pkg::job_t push_job,
    output logic          q_full,
    output logic          q_valid,
    output sai_pkg::job_t q_job,
    input  logic          pop
);

    sai_pkg::job_t          slot_reg [sai_pkg::QUEUE_DEPTH];
    logic [sai_pkg::QW-1:0] wr_ptr_reg;
    logic [sai_pkg::QW-1:0] rd_ptr_reg;
    logic [sai_pkg::QW:0]   level_reg;

    assign q_full  = (level_reg == (sai_pkg::QW + 1)'(sai_pkg::QUEUE_DEPTH));
    assign q_valid = (level_reg != '0);
    assign q_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### design/sai_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sai_back
// Carries out jobs on the element memory and drives the result register.
// ----------------------------------------------------------------------------
module sai_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  sai_pkg::job_t                 q_job,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [sai_pkg::DW-1:0] m_elem,
    output logic [4:0]                    m_position,
    output logic                          m_last,
    output logic [1:0]                    m_status
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EMIT = 2'b10
    } state_t;

    state_t                 state_reg, state_next;
    logic [sai_pkg::DW-1:0] mem [sai_pkg::STORE_DEPTH];
    logic [sai_pkg::DW-1:0] rd_data_reg;
    logic                   rd_en;
    logic [sai_pkg::AW-1:0] rd_addr;
    logic                   wr_en;
    logic [sai_pkg::AW-1:0] wr_addr;
    logic [sai_pkg::DW-1:0] wr_data;

    logic [sai_pkg::AW-1:0] idx_reg, idx_next;
    logic [sai_pkg::AW-1:0] end_reg, end_next;
    logic [sai_pkg::DW-1:0] ins_reg, ins_next;
    logic [sai_pkg::DW-1:0] carry_reg, carry_next;
    logic                   after_reg, after_next;

    logic                   m_valid_reg, m_valid_next;
    logic [sai_pkg::DW-1:0] elem_reg, elem_next;
    logic [4:0]             pos_reg, pos_next;
    logic                   last_reg, last_next;
    logic [1:0]             status_reg, status_next;

    logic                   out_free;
    logic                   at_end;
    logic                   less;

    assign out_free = !m_valid_reg || m_ready;
    assign at_end   = (idx_reg == end_reg);
    assign less     = !at_end && ($signed(rd_data_reg) < $signed(ins_reg));

    assign m_valid    = m_valid_reg;
    assign m_elem     = elem_reg;
    assign m_position = pos_reg;
    assign m_last     = last_reg;
    assign m_status   = status_reg;

    always_comb begin
        state_next   = state_reg;
        pop          = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        wr_addr      = idx_reg;
        wr_data      = ins_reg;
        idx_next     = idx_reg;
        end_next     = end_reg;
        ins_next     = ins_reg;
        carry_next   = carry_reg;
        after_next   = after_reg;
        m_valid_next = m_valid_reg && !m_ready;
        elem_next    = elem_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;
        status_next  = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (q_job.op == sai_pkg::OP_INSERT) begin
                        pop        = 1'b1;
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        end_next   = q_job.cnt[sai_pkg::AW-1:0];
                        ins_next   = q_job.value;
                        after_next = 1'b0;
                        state_next = S_EMIT;
                    end else if (out_free) begin
                        pop          = 1'b1;
                        m_valid_next = 1'b1;
                        elem_next    = '0;
                        pos_next     = '0;
                        last_next    = 1'b1;
                        case (q_job.op)
                            sai_pkg::OP_LOAD:    status_next = sai_pkg::ST_OK;
                            sai_pkg::OP_NOT_ASC: status_next = sai_pkg::ST_NOT_ASC;
                            default:             status_next = sai_pkg::ST_FULL;
                        endcase
                        if (q_job.op == sai_pkg::OP_LOAD) begin
                            wr_en   = 1'b1;
                            wr_addr = q_job.cnt[sai_pkg::AW-1:0];
                            wr_data = q_job.value;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    if (after_reg) begin
                        wr_data    = carry_reg;
                        carry_next = rd_data_reg;
                    end else if (less) begin
                        wr_data = rd_data_reg;
                    end else begin
                        wr_data    = ins_reg;
                        carry_next = rd_data_reg;
                        after_next = 1'b1;
                    end
                    wr_en        = 1'b1;
                    m_valid_next = 1'b1;
                    elem_next    = wr_data;
                    pos_next     = 5'(idx_reg);
                    last_next    = at_end;
                    status_next  = sai_pkg::ST_OK;
                    if (at_end) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        end_reg    <= end_next;
        ins_reg    <= ins_next;
        carry_reg  <= carry_next;
        after_reg  <= after_next;
        elem_reg   <= elem_next;
        pos_reg    <= pos_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

### design/sorted_array_insert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_array_insert_unit
// Ascending array of signed Q16.16 values with load, insert and readout.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    s_kind, s_value
//   m_       out  m_valid/m_ready    m_elem, m_position, m_last, m_status
//
// A load or a rejected beat gives a single result beat from the back end.
// An insert starts with one memory read, then emits one element per cycle while
// the output is free, reading the next entry while writing back the current one.
// A two-entry queue lets the front take beats while the back end works.
// Reset clears the element count; memory contents need no clearing.
// Either side may stall at any time; the result register holds its beat.
// ----------------------------------------------------------------------------
module sorted_array_insert_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_kind,
    input  logic signed [sai_pkg::DW-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [sai_pkg::DW-1:0] m_elem,
    output logic [4:0]                    m_position,
    output logic                          m_last,
    output logic [1:0]                    m_status
);

    logic          push;
    sai_pkg::job_t push_job;
    logic          q_full;
    logic          q_valid;
    sai_pkg::job_t q_job;
    logic          pop;

    sai_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_kind   (s_kind),
        .s_value  (s_value),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full)
    );

    sai_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .q_job    (q_job),
        .pop      (pop)
    );

    sai_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_job      (q_job),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_elem     (m_elem),
        .m_position (m_position),
        .m_last     (m_last),
        .m_status   (m_status)
    );

endmodule
